### rtl/bsal_pkg.sv
// Shared types and constants for the buffer slot allocate/lookup core.
`default_nettype none

package bsal_pkg;

  // Width of the block number field on the input word.
  localparam int unsigned BLK_W = 16;
  // Width of the disk size register.
  localparam int unsigned DISK_COUNT_W = 17;
  // Width of the reported slot index.
  localparam int unsigned IDX_W = 5;
  // Disk size after reset.
  localparam logic [DISK_COUNT_W-1:0] DISK_COUNT_RESET = 17'd8192;

  typedef enum logic {
    OP_ALLOC  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_OUT_OF_BOUND  = 2'd1,
    ST_NOT_IN_BUFFER = 2'd2,
    ST_NO_FREE_SLOT  = 2'd3
  } status_t;

  // Request token that travels down the row of slot cells.
  typedef struct packed {
    logic             valid;
    op_t              op;
    logic             done;
    status_t          status;
    logic [IDX_W-1:0] idx;
    logic [BLK_W-1:0] blk;
  } token_t;

endpackage

`default_nettype wire

### rtl/bsal_in_if.sv
// Request channel interface: valid/ready handshake carrying opcode and block number.
`default_nettype none

interface bsal_in_if import bsal_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [BLK_W-1:0] block_number;

  modport source (output valid, output opcode, output block_number, input ready);
  modport sink   (input valid, input opcode, input block_number, output ready);
endinterface

`default_nettype wire

### rtl/bsal_out_if.sv
// Result channel interface: valid/ready handshake carrying status and slot index.
`default_nettype none

interface bsal_out_if import bsal_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [IDX_W-1:0] slot_index;

  modport source (output valid, output status, output slot_index, input ready);
  modport sink   (input valid, input status, input slot_index, output ready);
endinterface

`default_nettype wire

### rtl/bsal_cell.sv
// One buffer slot: free bit, tag and one stage of the request token pipeline.
`default_nettype none

module bsal_cell import bsal_pkg::*; #(
  parameter int unsigned TAG_W      = 16,
  parameter int unsigned CELL_INDEX = 0
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   advance,
  input  wire token_t tok_i,
  output token_t      tok_o,
  output logic        free_o
);

  logic             free_r;
  logic             free_nxt;
  logic [TAG_W-1:0] tag_r;
  logic [TAG_W-1:0] tag_nxt;
  token_t           tok_r;
  token_t           tok_nxt;
  logic             live;
  logic             claim;
  logic             hit;

  assign live  = tok_i.valid && !tok_i.done;
  assign claim = live && (tok_i.op == OP_ALLOC) && free_r;
  assign hit   = live && (tok_i.op == OP_LOOKUP) && !free_r &&
                 (tag_r == tok_i.blk[TAG_W-1:0]);

  always_comb begin
    tok_nxt  = tok_i;
    free_nxt = free_r;
    tag_nxt  = tag_r;
    if (claim || hit) begin
      tok_nxt.done   = 1'b1;
      tok_nxt.status = ST_OK;
      tok_nxt.idx    = IDX_W'(CELL_INDEX);
    end
    if (claim) begin
      free_nxt = 1'b0;
      tag_nxt  = tok_i.blk[TAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r      <= 1'b1;
      tok_r.valid <= 1'b0;
    end else if (advance) begin
      free_r <= free_nxt;
      tok_r  <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tag_r <= tag_nxt;
    end
  end

  assign tok_o  = tok_r;
  assign free_o = free_r;

  // Slots are never released once claimed.
  a_no_release: assert property (@(posedge clk) disable iff (!rst_n)
    !free_r |=> !free_r)
    else $error("occupied slot became free");

  // A slot is claimed only by a live allocate token passing through.
  a_claim_src: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(free_r) |-> $past(advance && tok_i.valid && !tok_i.done && tok_i.op == OP_ALLOC))
    else $error("slot claimed without an allocate request");

  // A held stage keeps its token in place.
  a_tok_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(tok_r.valid))
    else $error("token moved while the row was stalled");

endmodule

`default_nettype wire

### rtl/buffer_slot_allocate_lookup_core.sv
// Top level of the buffer slot allocate/lookup core: bound check, slot cell row, result register.
`default_nettype none

// Buffer slot table for disk blocks. Each request word asks to allocate a slot
// for a block number (opcode 0) or to look one up (opcode 1), and gets exactly
// one result word back. A block number at or above the disk size register
// answers out of bound and touches nothing. Allocate claims the lowest free
// slot, stores the tag and returns its index, or answers no free slot when the
// table is full. Lookup returns the lowest occupied slot with a matching tag,
// or not in buffer. The slot index is zero whenever the status is not ok.
// The table is a row of SLOT_COUNT identical cells; a request token enters
// cell 0 and moves one cell per cycle, so cell k sees requests in arrival
// order and the lowest slot always wins. The row is fully pipelined: one word
// is accepted per cycle, and each request passes the register of every cell
// and then the result register before its result appears. When the result
// register is full and not taken, the whole row holds and the request side
// is not ready. All slots are free after reset; there is no release other
// than reset. The disk size register resets to 8192 and should be written
// only while no request is in flight.

module buffer_slot_allocate_lookup_core import bsal_pkg::*; #(
  parameter int unsigned SLOT_COUNT         = 32,
  parameter int unsigned BLOCK_NUMBER_WIDTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  bsal_in_if.sink                      in_ch,
  bsal_out_if.source                   out_ch,
  input  wire logic                    cfg_we,
  input  wire logic [DISK_COUNT_W-1:0] cfg_wdata
);

  // Tags keep only the bits of the block number that are significant.
  localparam int unsigned TAG_W =
    (BLOCK_NUMBER_WIDTH < BLK_W) ? BLOCK_NUMBER_WIDTH : BLK_W;
  localparam logic [BLK_W-1:0] BLK_MASK = BLK_W'((17'd1 << TAG_W) - 17'd1);

  logic [DISK_COUNT_W-1:0] disk_block_count_r;
  logic                    advance;
  logic [BLK_W-1:0]        blk_in;
  logic                    out_of_bound;
  token_t                  tok_w [SLOT_COUNT+1];
  logic [SLOT_COUNT-1:0]   free_vec;

  logic                    out_valid_r;
  logic                    out_valid_nxt;
  status_t                 out_status_r;
  status_t                 out_status_nxt;
  logic [IDX_W-1:0]        out_idx_r;
  logic [IDX_W-1:0]        out_idx_nxt;

  // Disk size register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_block_count_r <= DISK_COUNT_RESET;
    end else if (cfg_we) begin
      disk_block_count_r <= cfg_wdata;
    end
  end

  // The whole row moves whenever the result register can take a new word.
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = advance;

  // Entry: mask the block number and settle the bound check before the row.
  // An out-of-bound request enters already finished so no cell acts on it.
  assign blk_in       = in_ch.block_number & BLK_MASK;
  assign out_of_bound = ({1'b0, blk_in} >= disk_block_count_r);

  always_comb begin
    tok_w[0].valid  = in_ch.valid;
    tok_w[0].op     = op_t'(in_ch.opcode);
    tok_w[0].done   = out_of_bound;
    tok_w[0].status = out_of_bound ? ST_OUT_OF_BOUND : ST_OK;
    tok_w[0].idx    = '0;
    tok_w[0].blk    = blk_in;
  end

  for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
    bsal_cell #(
      .TAG_W      (TAG_W),
      .CELL_INDEX (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .tok_i   (tok_w[k]),
      .tok_o   (tok_w[k+1]),
      .free_o  (free_vec[k])
    );
  end

  // A token that leaves the row unfinished found no free slot or no match.
  always_comb begin
    out_valid_nxt  = tok_w[SLOT_COUNT].valid;
    out_status_nxt = tok_w[SLOT_COUNT].status;
    out_idx_nxt    = tok_w[SLOT_COUNT].idx;
    if (!tok_w[SLOT_COUNT].done) begin
      out_status_nxt = (tok_w[SLOT_COUNT].op == OP_ALLOC) ? ST_NO_FREE_SLOT
                                                          : ST_NOT_IN_BUFFER;
      out_idx_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= out_status_nxt;
      out_idx_r    <= out_idx_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.slot_index = out_idx_r;

  // Any status other than ok carries a zero slot index.
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_idx_r == '0))
    else $error("nonzero slot index with a failing status");

  // The number of free slots never grows between resets.
  a_free_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ($countones(free_vec) <= $past($countones(free_vec))))
    else $error("free slot count increased");

  // While the row is held, no slot changes state.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(free_vec))
    else $error("slot state changed while the row was stalled");

endmodule

`default_nettype wire
